// ===== hw/rtl/ipsd_pkg.sv =====
package ipsd_pkg;

   localparam int OFFSET_BYTES = 3;
   localparam int SIZE_BYTES   = 2;
   localparam int COUNT_BYTES  = 2;
   localparam int HEADER_BYTES = 5;

   localparam logic [23:0] EOF_MARK = 24'h454F46;

   typedef enum logic [2:0] {
      KIND_WRITE      = 3'd0,
      KIND_FILL       = 3'd1,
      KIND_DONE       = 3'd2,
      KIND_BAD_HEADER = 3'd3,
      KIND_TRUNCATED  = 3'd4
   } kind_type;

   // one queue entry: first result of a word, plus an optional trailing finish
   typedef struct packed {
      kind_type      kind;
      logic [24:0]   addr;
      logic [7:0]    data;
      logic [15:0]   count;
      logic [24:0]   length;
      logic          extra_done;
   } entry_type;

   function automatic logic [7:0] magic_byte(input logic [2:0] idx);
      logic [7:0] val;
      case (idx)
         3'd0: val = 8'h50;
         3'd1: val = 8'h41;
         3'd2: val = 8'h54;
         3'd3: val = 8'h43;
         3'd4: val = 8'h48;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

// ===== hw/rtl/ipsd_front.sv =====
module ipsd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tlast,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [24:0]         csr_data,
   input  logic                q_full,
   output logic                push,
   output ipsd_pkg::entry_type push_entry
);
   import ipsd_pkg::*;

   typedef enum logic [6:0] {
      PH_HEADER    = 7'b0000001,
      PH_OFFSET    = 7'b0000010,
      PH_SIZE      = 7'b0000100,
      PH_DATA      = 7'b0001000,
      PH_RLE_COUNT = 7'b0010000,
      PH_RLE_BYTE  = 7'b0100000,
      PH_DISCARD   = 7'b1000000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  fbc_ff, fbc_in;
   logic [23:0] offset_ff, offset_in;
   logic [15:0] size_ff, size_in;
   logic [15:0] rem_ff, rem_in;
   logic [24:0] wptr_ff, wptr_in;
   logic [24:0] cur_len_ff, cur_len_in;
   logic [24:0] base_len_ff, base_len_in;

   logic        accept;
   logic [7:0]  b;
   logic        last;
   logic [2:0]  fbc_inc;
   logic [23:0] off_shift;
   logic [15:0] size_shift;
   logic [15:0] rem_shift;
   logic [15:0] rem_dec;
   logic [15:0] span;
   logic [24:0] ext_sum;
   logic [24:0] ext_len;
   logic [24:0] hdr_len;

   assign req_tready  = !q_full;
   assign csr_ready   = 1'b1;
   assign accept      = req_tvalid && req_tready;
   assign b           = req_tdata;
   assign last        = req_tlast;
   assign fbc_inc     = fbc_ff + 3'd1;
   assign off_shift   = {offset_ff[15:0], b};
   assign size_shift  = {size_ff[7:0], b};
   assign rem_shift   = {rem_ff[7:0], b};
   assign rem_dec     = rem_ff - 16'd1;
   assign span        = (phase_ff == PH_SIZE) ? size_shift : rem_ff;
   assign ext_sum     = {1'b0, offset_ff} + {9'd0, span};
   assign ext_len     = (ext_sum > cur_len_ff) ? ext_sum : cur_len_ff;
   assign hdr_len     = (fbc_ff == 3'd0) ? base_len_ff : cur_len_ff;
   assign base_len_in = csr_valid ? csr_data : base_len_ff;

   always_comb begin
      phase_in   = phase_ff;
      fbc_in     = fbc_ff;
      offset_in  = offset_ff;
      size_in    = size_ff;
      rem_in     = rem_ff;
      wptr_in    = wptr_ff;
      cur_len_in = cur_len_ff;
      push       = 1'b0;
      push_entry = '0;
      if (accept) begin
         case (phase_ff)
            PH_HEADER: begin
               cur_len_in = hdr_len;
               if (b != magic_byte(fbc_ff)) begin
                  push            = 1'b1;
                  push_entry.kind = KIND_BAD_HEADER;
                  phase_in        = PH_DISCARD;
               end else if (fbc_inc == 3'(HEADER_BYTES)) begin
                  phase_in  = PH_OFFSET;
                  fbc_in    = 3'd0;
                  offset_in = '0;
                  if (last) begin
                     push              = 1'b1;
                     push_entry.kind   = KIND_DONE;
                     push_entry.length = hdr_len;
                  end
               end else begin
                  fbc_in = fbc_inc;
                  if (last) begin
                     push            = 1'b1;
                     push_entry.kind = KIND_BAD_HEADER;
                  end
               end
            end
            PH_OFFSET: begin
               offset_in = off_shift;
               if (fbc_inc >= 3'(OFFSET_BYTES)) begin
                  fbc_in = 3'd0;
                  if (off_shift == EOF_MARK) begin
                     push              = 1'b1;
                     push_entry.kind   = KIND_DONE;
                     push_entry.length = cur_len_ff;
                     phase_in          = PH_DISCARD;
                  end else begin
                     phase_in = PH_SIZE;
                     size_in  = '0;
                     if (last) begin
                        push            = 1'b1;
                        push_entry.kind = KIND_TRUNCATED;
                     end
                  end
               end else begin
                  fbc_in = fbc_inc;
                  if (last) begin
                     push              = 1'b1;
                     push_entry.kind   = KIND_DONE;
                     push_entry.length = cur_len_ff;
                  end
               end
            end
            PH_SIZE: begin
               size_in = size_shift;
               if (fbc_inc >= 3'(SIZE_BYTES)) begin
                  fbc_in     = 3'd0;
                  cur_len_in = ext_len;
                  if (size_shift != 16'd0) begin
                     rem_in   = size_shift;
                     wptr_in  = {1'b0, offset_ff};
                     phase_in = PH_DATA;
                     if (last) begin
                        push              = 1'b1;
                        push_entry.kind   = KIND_DONE;
                        push_entry.length = ext_len;
                     end
                  end else begin
                     rem_in   = '0;
                     phase_in = PH_RLE_COUNT;
                     if (last) begin
                        push            = 1'b1;
                        push_entry.kind = KIND_TRUNCATED;
                     end
                  end
               end else begin
                  fbc_in = fbc_inc;
                  if (last) begin
                     push            = 1'b1;
                     push_entry.kind = KIND_TRUNCATED;
                  end
               end
            end
            PH_DATA: begin
               push                  = 1'b1;
               push_entry.kind       = KIND_WRITE;
               push_entry.addr       = wptr_ff;
               push_entry.data       = b;
               push_entry.extra_done = last;
               push_entry.length     = cur_len_ff;
               wptr_in               = wptr_ff + 25'd1;
               rem_in                = rem_dec;
               if (rem_dec == 16'd0) begin
                  phase_in  = PH_OFFSET;
                  fbc_in    = 3'd0;
                  offset_in = '0;
               end
            end
            PH_RLE_COUNT: begin
               rem_in = rem_shift;
               if (fbc_inc >= 3'(COUNT_BYTES)) begin
                  fbc_in   = 3'd0;
                  phase_in = PH_RLE_BYTE;
               end else begin
                  fbc_in = fbc_inc;
               end
               if (last) begin
                  push            = 1'b1;
                  push_entry.kind = KIND_TRUNCATED;
               end
            end
            PH_RLE_BYTE: begin
               cur_len_in            = ext_len;
               push                  = 1'b1;
               push_entry.kind       = KIND_FILL;
               push_entry.addr       = {1'b0, offset_ff};
               push_entry.data       = b;
               push_entry.count      = rem_ff;
               push_entry.extra_done = last;
               push_entry.length     = ext_len;
               phase_in              = PH_OFFSET;
               fbc_in                = 3'd0;
               offset_in             = '0;
            end
            default: begin
            end
         endcase
         if (last) begin
            phase_in = PH_HEADER;
            fbc_in   = 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         fbc_ff      <= '0;
         offset_ff   <= '0;
         size_ff     <= '0;
         rem_ff      <= '0;
         wptr_ff     <= '0;
         cur_len_ff  <= '0;
         base_len_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         fbc_ff      <= fbc_in;
         offset_ff   <= offset_in;
         size_ff     <= size_in;
         rem_ff      <= rem_in;
         wptr_ff     <= wptr_in;
         cur_len_ff  <= cur_len_in;
         base_len_ff <= base_len_in;
      end
   end

endmodule

// ===== hw/rtl/ipsd_queue.sv =====
module ipsd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ipsd_pkg::entry_type push_entry,
   input  logic                pop,
   output ipsd_pkg::entry_type head,
   output logic                empty,
   output logic                full
);
   import ipsd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH)) else $error("queue count out of range");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("pop from empty queue");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count did not advance");
`endif

endmodule

// ===== hw/rtl/ipsd_back.sv =====
module ipsd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  ipsd_pkg::entry_type q_head,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [79:0]         rsp_tdata,
   output logic [2:0]          rsp_tuser,
   output logic                rsp_tlast
);
   import ipsd_pkg::*;

   logic        valid_ff, valid_in;
   logic        pend_ff, pend_in;
   logic [24:0] pend_len_ff, pend_len_in;
   kind_type    kind_ff, kind_in;
   logic [24:0] addr_ff, addr_in;
   logic [7:0]  data_ff, data_in;
   logic [15:0] count_ff, count_in;
   logic [24:0] len_ff, len_in;
   logic        last_ff, last_in;
   logic        load;

   assign load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in    = valid_ff;
      pend_in     = pend_ff;
      pend_len_in = pend_len_ff;
      kind_in     = kind_ff;
      addr_in     = addr_ff;
      data_in     = data_ff;
      count_in    = count_ff;
      len_in      = len_ff;
      last_in     = last_ff;
      pop         = 1'b0;
      if (load) begin
         if (pend_ff) begin
            valid_in = 1'b1;
            pend_in  = 1'b0;
            kind_in  = KIND_DONE;
            addr_in  = '0;
            data_in  = '0;
            count_in = '0;
            len_in   = pend_len_ff;
            last_in  = 1'b1;
         end else if (!q_empty) begin
            pop         = 1'b1;
            valid_in    = 1'b1;
            kind_in     = q_head.kind;
            addr_in     = q_head.addr;
            data_in     = q_head.data;
            count_in    = q_head.count;
            len_in      = (q_head.kind == KIND_DONE) ? q_head.length : '0;
            last_in     = !q_head.extra_done;
            pend_in     = q_head.extra_done;
            pend_len_in = q_head.length;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_len_ff <= pend_len_in;
      kind_ff     <= kind_in;
      addr_ff     <= addr_in;
      data_ff     <= data_in;
      count_ff    <= count_in;
      len_ff      <= len_in;
      last_ff     <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'd0, len_ff, count_ff, data_ff, addr_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== hw/rtl/ips_patch_stream_decoder_core.sv =====
// path: a word's first result passes through the result queue and then the output register before it is on rsp
// throughput: one patch byte per cycle while the result queue is not full; a data or fill byte that is also the final
// stream byte yields two results on rsp
// rate is set by the result queue (QUEUE_DEPTH entries) and the single output register
// reset (synchronous, active high): parser expects a header, queue empty, base_length 0
module ips_patch_stream_decoder_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // patch_byte
   input  logic        req_tlast,   // stream_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // target_address, write_data, fill_count, image_length
   output logic [2:0]  rsp_tuser,   // command_kind
   output logic        rsp_tlast,   // run_last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [24:0] csr_data
);
   import ipsd_pkg::*;

   logic      push;
   entry_type push_entry;
   logic      pop;
   entry_type head;
   logic      q_empty;
   logic      q_full;

   ipsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   ipsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (q_empty),
      .full       (q_full)
   );

   ipsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== tb/testbench.sv =====
module testbench;
   import ipsd_pkg::*;

   typedef enum logic [2:0] {
      ST_HEADER,
      ST_OFFSET,
      ST_SIZE,
      ST_DATA,
      ST_COUNT,
      ST_FILL,
      ST_IDLE
   } phase_type;

   typedef struct packed {
      kind_type     kind;
      logic [24:0]  addr;
      logic [7:0]   data;
      logic [15:0]  count;
      logic [24:0]  length;
      logic         last;
   } patch_cmd_type;

   typedef struct packed {
      logic [7:0]   b;
      logic         fin;
      logic         fixed;
      kind_type     kind;
      logic [24:0]  length;
   } row_type;

   localparam logic [39:0] MAGIC = "PATCH";
   localparam logic [24:0] BASE_MAX = 25'd16777216;
   localparam int RANDOM_WORDS = 1350;

   // extremes of offset, size, data and count, then header errors
   localparam row_type DIRECTED_ROWS [0:25] = '{
      '{8'h50, 1'b0, 1'b0, KIND_WRITE, 25'd0},
      '{8'h41, 1'b0, 1'b0, KIND_WRITE, 25'd0},
      '{8'h54, 1'b0, 1'b0, KIND_WRITE, 25'd0},
      '{8'h43, 1'b0, 1'b0, KIND_WRITE, 25'd0},
      '{8'h48, 1'b0, 1'b0, KIND_WRITE, 25'd0},
      '{8'hFF, 1'b0, 1'b0, KIND_WRITE, 25'd0},
      '{8'hFF, 1'b0, 1'b0, KIND_WRITE, 25'd0},
      '{8'hFF, 1'b0, 1'b0, KIND_WRITE, 25'd0},
      '{8'h00, 1'b0, 1'b0, KIND_WRITE, 25'd0},
      '{8'h02, 1'b0, 1'b0, KIND_WRITE, 25'd0},
      '{8'h00, 1'b0, 1'b0, KIND_WRITE, 25'd0},
      '{8'hFF, 1'b0, 1'b0, KIND_WRITE, 25'd0},
      '{8'h00, 1'b0, 1'b0, KIND_WRITE, 25'd0},
      '{8'h00, 1'b0, 1'b0, KIND_WRITE, 25'd0},
      '{8'h00, 1'b0, 1'b0, KIND_WRITE, 25'd0},
      '{8'h00, 1'b0, 1'b0, KIND_WRITE, 25'd0},
      '{8'h00, 1'b0, 1'b0, KIND_WRITE, 25'd0},
      '{8'hFF, 1'b0, 1'b0, KIND_WRITE, 25'd0},
      '{8'hFF, 1'b0, 1'b0, KIND_WRITE, 25'd0},
      '{8'hAB, 1'b1, 1'b0, KIND_WRITE, 25'd0},
      '{8'h50, 1'b0, 1'b0, KIND_WRITE, 25'd0},
      '{8'h58, 1'b0, 1'b1, KIND_BAD_HEADER, 25'd0},
      '{8'h5A, 1'b1, 1'b0, KIND_WRITE, 25'd0},
      '{8'h50, 1'b0, 1'b0, KIND_WRITE, 25'd0},
      '{8'h41, 1'b0, 1'b0, KIND_WRITE, 25'd0},
      '{8'h54, 1'b1, 1'b1, KIND_BAD_HEADER, 25'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [24:0] csr_data = 25'd0;

   // decoder state as predicted
   phase_type     phase = ST_HEADER;
   int            fld_cnt = 0;
   logic [23:0]   rec_off = '0;
   logic [15:0]   rec_size = '0;
   logic [15:0]   remaining = '0;
   logic [24:0]   wr_ptr = '0;
   logic [24:0]   img_len = '0;
   logic [24:0]   base_len = '0;
   patch_cmd_type step_out [2];

   patch_cmd_type pending_cmds [$];
   logic [7:0]    stream_bytes [$];
   int            mismatches = 0;
   bit            req_calm = 1'b0;

   always #1 clock = ~clock;

   ips_patch_stream_decoder_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   function automatic int emit(input int n, input kind_type k, input logic [24:0] a,
                               input logic [7:0] d, input logic [15:0] c,
                               input logic [24:0] len);
      step_out[n] = '{kind: k, addr: a, data: d, count: c, length: len, last: 1'b0};
      return n + 1;
   endfunction

   function automatic int finish_ok(input int n);
      phase = ST_IDLE;
      return emit(n, KIND_DONE, 25'd0, 8'd0, 16'd0, img_len);
   endfunction

   function automatic int stop_with(input int n, input kind_type k);
      phase = ST_IDLE;
      return emit(n, k, 25'd0, 8'd0, 16'd0, 25'd0);
   endfunction

   function automatic void start_record();
      phase = ST_OFFSET;
      fld_cnt = 0;
      rec_off = '0;
   endfunction

   function automatic void grow_length(input logic [23:0] start, input logic [15:0] span);
      logic [24:0] stop;
      stop = {1'b0, start} + {9'd0, span};
      if (stop > img_len) img_len = stop;
   endfunction

   function automatic int decode_byte(input logic [7:0] b, input logic fin);
      int n;
      n = 0;
      case (phase)
         ST_HEADER: begin
            if (fld_cnt == 0) img_len = base_len;
            if (b != MAGIC[39 - 8 * fld_cnt -: 8]) begin
               n = stop_with(n, KIND_BAD_HEADER);
            end else begin
               fld_cnt++;
               if (fld_cnt == HEADER_BYTES) begin
                  start_record();
                  if (fin) n = finish_ok(n);
               end else if (fin) begin
                  n = stop_with(n, KIND_BAD_HEADER);
               end
            end
         end
         ST_OFFSET: begin
            rec_off = {rec_off[15:0], b};
            fld_cnt++;
            if (fld_cnt >= OFFSET_BYTES) begin
               fld_cnt = 0;
               if (rec_off == EOF_MARK) begin
                  n = finish_ok(n);
               end else begin
                  phase = ST_SIZE;
                  rec_size = '0;
                  if (fin) n = stop_with(n, KIND_TRUNCATED);
               end
            end else if (fin) begin
               n = finish_ok(n);
            end
         end
         ST_SIZE: begin
            rec_size = {rec_size[7:0], b};
            fld_cnt++;
            if (fld_cnt >= SIZE_BYTES) begin
               fld_cnt = 0;
               grow_length(rec_off, rec_size);
               if (rec_size != 0) begin
                  remaining = rec_size;
                  wr_ptr = {1'b0, rec_off};
                  phase = ST_DATA;
                  if (fin) n = finish_ok(n);
               end else begin
                  remaining = '0;
                  phase = ST_COUNT;
                  if (fin) n = stop_with(n, KIND_TRUNCATED);
               end
            end else if (fin) begin
               n = stop_with(n, KIND_TRUNCATED);
            end
         end
         ST_DATA: begin
            n = emit(n, KIND_WRITE, wr_ptr, b, 16'd0, 25'd0);
            wr_ptr = wr_ptr + 25'd1;
            remaining = remaining - 16'd1;
            if (remaining == 0) start_record();
            if (fin) n = finish_ok(n);
         end
         ST_COUNT: begin
            remaining = {remaining[7:0], b};
            fld_cnt++;
            if (fld_cnt >= COUNT_BYTES) begin
               fld_cnt = 0;
               phase = ST_FILL;
            end
            if (fin) n = stop_with(n, KIND_TRUNCATED);
         end
         ST_FILL: begin
            grow_length(rec_off, remaining);
            n = emit(n, KIND_FILL, {1'b0, rec_off}, b, remaining, 25'd0);
            start_record();
            if (fin) n = finish_ok(n);
         end
         default: begin
         end
      endcase
      if (fin) begin
         phase = ST_HEADER;
         fld_cnt = 0;
      end
      if (n > 0) step_out[n - 1].last = 1'b1;
      return n;
   endfunction

   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 75) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // called at a rising edge; returns at a rising edge
   task automatic send_word(input logic [7:0] b, input logic fin, input bit fixed,
                            input patch_cmd_type fixed_cmd);
      int n;
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= fin;
      do @(posedge clock); while (!req_tready);
      n = decode_byte(b, fin);
      if (fixed) begin
         pending_cmds.push_back(fixed_cmd);
      end else begin
         for (int i = 0; i < n; i++) pending_cmds.push_back(step_out[i]);
      end
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_base(input logic [24:0] v);
      settle();
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      base_len = v;
   endtask

   task automatic push_byte(input logic [7:0] b);
      stream_bytes.push_back(b);
   endtask

   task automatic add_record(output bit cut);
      logic [23:0] off;
      logic [15:0] sz;
      logic [15:0] cnt;
      int r;
      int nsend;
      cut = 1'b0;
      r = $urandom_range(0, 9);
      if (r < 4) off = 24'($urandom_range(0, 255));
      else if (r < 9) off = 24'($urandom);
      else off = {16'hFFFF, 8'($urandom)};
      push_byte(off[23:16]);
      push_byte(off[15:8]);
      push_byte(off[7:0]);
      if ($urandom_range(0, 99) < 65) begin
         r = $urandom_range(0, 99);
         if (r < 90) sz = 16'($urandom_range(1, 12));
         else if (r < 97) sz = 16'($urandom_range(13, 64));
         else sz = 16'($urandom_range(1, 65535));
         push_byte(sz[15:8]);
         push_byte(sz[7:0]);
         // huge records are cut short, which ends the stream
         nsend = (sz > 64) ? $urandom_range(1, 20) : int'(sz);
         repeat (nsend) push_byte(8'($urandom));
         cut = (nsend < sz);
      end else begin
         cnt = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 16)) : 16'($urandom);
         push_byte(8'h00);
         push_byte(8'h00);
         push_byte(cnt[15:8]);
         push_byte(cnt[7:0]);
         push_byte(8'($urandom));
      end
   endtask

   task automatic build_stream();
      int r;
      int nrec;
      int k;
      bit cut;
      logic [39:0] hdr;
      stream_bytes.delete();
      r = $urandom_range(0, 99);
      if (r < 10) begin
         repeat ($urandom_range(1, 10)) push_byte(8'($urandom));
         if (r < 5) stream_bytes[0] = MAGIC[39:32];
      end else begin
         hdr = MAGIC;
         if ($urandom_range(0, 19) == 0) begin
            k = $urandom_range(0, 39);
            hdr[k] = ~hdr[k];
         end
         for (int i = 0; i < HEADER_BYTES; i++) push_byte(hdr[39 - 8 * i -: 8]);
         nrec = $urandom_range(0, 5);
         cut = 1'b0;
         for (int i = 0; i < nrec && !cut; i++) add_record(cut);
         if (!cut && $urandom_range(0, 99) < 70) begin
            push_byte(EOF_MARK[23:16]);
            push_byte(EOF_MARK[15:8]);
            push_byte(EOF_MARK[7:0]);
            repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
         end
         if (r < 35) begin
            k = $urandom_range(1, stream_bytes.size());
            while (stream_bytes.size() > k) void'(stream_bytes.pop_back());
         end
      end
   endtask

   function automatic void compare_field(input string name, input logic [24:0] want,
                                         input logic [24:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 50)
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
   endfunction

   task automatic check_rsp();
      patch_cmd_type want;
      if (pending_cmds.size() == 0) begin
         mismatches++;
         if (mismatches <= 50)
            $display("%0t: word expected none actual kind %0d tdata %h",
                     $time, rsp_tuser, rsp_tdata);
         return;
      end
      want = pending_cmds.pop_front();
      compare_field("command_kind", 25'(want.kind), 25'(rsp_tuser));
      compare_field("target_address", want.addr, rsp_tdata[24:0]);
      compare_field("write_data", 25'(want.data), 25'(rsp_tdata[32:25]));
      compare_field("fill_count", 25'(want.count), 25'(rsp_tdata[48:33]));
      compare_field("image_length", want.length, rsp_tdata[73:49]);
      compare_field("run_last", 25'(want.last), 25'(rsp_tlast));
   endtask

   initial begin
      int stall;
      int r;
      bit calm;
      stall = 0;
      calm = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready) check_rsp();
         if ($urandom_range(0, 299) == 0) calm = !calm;
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (calm || r < 70) begin
               rsp_tready <= 1'b1;
            end else begin
               stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
               rsp_tready <= 1'b0;
            end
         end
      end
   end

   initial begin
      int sent;
      int cfg_writes;
      patch_cmd_type fixed_cmd;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         fixed_cmd = '{kind: DIRECTED_ROWS[i].kind, addr: 25'd0, data: 8'd0, count: 16'd0,
                       length: DIRECTED_ROWS[i].length, last: 1'b1};
         send_word(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].fin, DIRECTED_ROWS[i].fixed,
                   fixed_cmd);
      end

      write_base(BASE_MAX);
      sent = 0;
      cfg_writes = 0;
      while (sent < RANDOM_WORDS) begin
         if ($urandom_range(0, 5) == 0) begin
            cfg_writes++;
            case (cfg_writes % 3)
               0: write_base(BASE_MAX);
               1: write_base(25'd0);
               default: write_base(25'($urandom_range(0, BASE_MAX)));
            endcase
         end
         req_calm = ($urandom_range(0, 4) == 0);
         build_stream();
         foreach (stream_bytes[i])
            send_word(stream_bytes[i], i == stream_bytes.size() - 1, 1'b0, '0);
         sent += stream_bytes.size();
      end

      req_tvalid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== ips_patch_stream_decoder_core.f =====
hw/rtl/ipsd_pkg.sv
hw/rtl/ipsd_front.sv
hw/rtl/ipsd_queue.sv
hw/rtl/ipsd_back.sv
hw/rtl/ips_patch_stream_decoder_core.sv
tb/testbench.sv
